>>> src/svgt_pkg.sv
// Package for the SVG path command tokenizer: state and token codes,
// character constants, queue sizing and the action record type.
// No dependencies.
package svgt_pkg;

    // parser states
    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_DELIM  = 3'd1;
    localparam logic [2:0] ST_TYPE   = 3'd2;
    localparam logic [2:0] ST_NUMBER = 3'd3;
    localparam logic [2:0] ST_NUMEND = 3'd4;
    localparam logic [2:0] ST_ERROR  = 3'd5;

    // token kinds
    localparam logic [1:0] TK_START = 2'd0;
    localparam logic [1:0] TK_DIGIT = 2'd1;
    localparam logic [1:0] TK_END   = 2'd2;
    localparam logic [1:0] TK_ERROR = 2'd3;

    // move types
    localparam logic [1:0] MT_MOVE = 2'd0;
    localparam logic [1:0] MT_ARC  = 2'd1;
    localparam logic [1:0] MT_LINE = 2'd2;

    // number start flags
    localparam logic [1:0] NS_CONT  = 2'd0;
    localparam logic [1:0] NS_FIRST = 2'd1;
    localparam logic [1:0] NS_LATER = 2'd2;

    // characters
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // action queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one classified character: the final token, preceded by a command end
    // when pre_end is set
    typedef struct packed {
        logic       pre_end;
        logic [1:0] kind;
        logic [1:0] move_type;
        logic [3:0] digit;
        logic [1:0] nstart;
    } t_action;

endpackage

>>> src/svgt_if.sv
// Handshake channels of the tokenizer: character input and token output.
// Depends on nothing.
interface svgt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface svgt_token_if;
    logic       valid;
    logic       ready;
    logic [1:0] token_kind;
    logic [1:0] move_type;
    logic [3:0] digit_value;
    logic [1:0] number_start;
    logic       last;

    modport source (output valid, output token_kind, output move_type,
                    output digit_value, output number_start, output last,
                    input ready);
    modport sink   (input valid, input token_kind, input move_type,
                    input digit_value, input number_start, input last,
                    output ready);
endinterface

>>> src/svgt_front.sv
// Front of the tokenizer: accepts characters, runs the parse state machine
// and pushes one action record per token-producing character. Uses svgt_pkg.
module svgt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char_code,
    output logic              o_ready,
    input  logic              i_queue_full,
    output logic              o_push,
    output svgt_pkg::t_action o_action
);
    import svgt_pkg::*;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       act_vld;
    t_action    act;
    logic       accept;
    logic [7:0] digit_off;
    logic       is_digit;

    assign o_ready   = !i_queue_full;
    assign accept    = i_valid && o_ready;
    assign digit_off = i_char_code - CH_0;
    assign is_digit  = (i_char_code >= CH_0) && (i_char_code <= CH_9);

    // classify the character against the current state
    always_comb begin
        n_state = r_state;
        act_vld = 1'b0;
        act     = '0;
        if (r_state >= ST_ERROR) begin
            n_state  = ST_ERROR;
            act_vld  = 1'b1;
            act.kind = TK_ERROR;
        end else if (i_char_code == CH_SPACE) begin
            if (r_state == ST_NUMBER) begin
                n_state = ST_NUMEND;
            end
        end else if (i_char_code == CH_QUOTE) begin
            if (r_state == ST_INIT || r_state == ST_NUMBER || r_state == ST_NUMEND) begin
                n_state = ST_DELIM;
            end else begin
                n_state  = ST_ERROR;
                act_vld  = 1'b1;
                act.kind = TK_ERROR;
            end
        end else if (i_char_code == CH_LF || i_char_code == CH_CR) begin
            act_vld = 1'b1;
            if (r_state == ST_NUMBER || r_state == ST_NUMEND || r_state == ST_DELIM) begin
                n_state  = ST_INIT;
                act.kind = TK_END;
            end else begin
                n_state  = ST_ERROR;
                act.kind = TK_ERROR;
            end
        end else if (i_char_code == CH_M || i_char_code == CH_A || i_char_code == CH_L) begin
            act_vld = 1'b1;
            act.move_type = (i_char_code == CH_M) ? MT_MOVE :
                            ((i_char_code == CH_A) ? MT_ARC : MT_LINE);
            if (r_state == ST_INIT || r_state == ST_DELIM || r_state == ST_NUMEND) begin
                n_state     = ST_TYPE;
                act.kind    = TK_START;
                act.pre_end = (r_state == ST_NUMEND);
            end else begin
                n_state       = ST_ERROR;
                act.kind      = TK_ERROR;
                act.move_type = MT_MOVE;
            end
        end else if (is_digit) begin
            act_vld = 1'b1;
            if (r_state == ST_TYPE || r_state == ST_NUMEND || r_state == ST_NUMBER) begin
                n_state    = ST_NUMBER;
                act.kind   = TK_DIGIT;
                act.digit  = digit_off[3:0];
                act.nstart = (r_state == ST_TYPE) ? NS_FIRST :
                             ((r_state == ST_NUMEND) ? NS_LATER : NS_CONT);
            end else begin
                n_state  = ST_ERROR;
                act.kind = TK_ERROR;
            end
        end else begin
            n_state  = ST_ERROR;
            act_vld  = 1'b1;
            act.kind = TK_ERROR;
        end
    end

    assign o_push   = accept && act_vld;
    assign o_action = act;

    // state register, advanced on every accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/svgt_queue.sv
// Short action queue between front and back of the tokenizer.
// Uses svgt_pkg for depth and record type.
module svgt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  svgt_pkg::t_action i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output svgt_pkg::t_action o_head
);
    import svgt_pkg::*;

    t_action           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == QUEUE_DEPTH[QPTR_W:0]);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full action queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty action queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_DEPTH[QPTR_W:0]) else $error("queue count out of range");
`endif

endmodule

>>> src/svgt_back.sv
// Back of the tokenizer: expands action records into one or two tokens and
// holds them in the output register. Uses svgt_pkg.
module svgt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_empty,
    input  svgt_pkg::t_action i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_token_kind,
    output logic [1:0]        o_move_type,
    output logic [3:0]        o_digit_value,
    output logic [1:0]        o_number_start,
    output logic              o_last
);
    import svgt_pkg::*;

    logic       r_valid;
    logic       r_phase;      // command end of a two-token record already shown
    logic [1:0] r_kind;
    logic [1:0] r_mtype;
    logic [3:0] r_digit;
    logic [1:0] r_nstart;
    logic       r_last;
    logic       load;
    logic       first_half;

    assign load       = !i_head_empty && (!r_valid || i_ready);
    assign first_half = i_head.pre_end && !r_phase;
    assign o_pop      = load && !first_half;

    // output valid and expansion phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= first_half;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (first_half) begin
                r_kind   <= TK_END;
                r_mtype  <= MT_MOVE;
                r_digit  <= '0;
                r_nstart <= NS_CONT;
                r_last   <= 1'b0;
            end else begin
                r_kind   <= i_head.kind;
                r_mtype  <= i_head.move_type;
                r_digit  <= i_head.digit;
                r_nstart <= i_head.nstart;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_token_kind   = r_kind;
    assign o_move_type    = r_mtype;
    assign o_digit_value  = r_digit;
    assign o_number_start = r_nstart;
    assign o_last         = r_last;

`ifndef SYNTHESIS
    a_phase_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!i_head_empty && i_head.pre_end))
        else $error("second half pending without its record");
    a_phase_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_valid && !r_last && r_kind == TK_END))
        else $error("expansion phase without command end on output");
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last)) else $error("pop without final token");
`endif

endmodule

>>> src/svg_path_command_tokenizer.sv
// Channel    | Dir | Beat payload
// i_char     | in  | char_code[7:0]
// o_token    | out | token_kind, move_type, digit_value, number_start, last
//
// One character is accepted per cycle while the action queue has room.
// A token passes the action queue, then the output register. A letter that
// closes a command yields two tokens, a command end and then its start, so
// the output port sets the sustained rate when such letters are frequent.
// Synchronous active-low reset returns the parser to awaiting a command.
// A stalled output fills the four-entry queue, then i_char.ready drops.
//
// Top level of the tokenizer: front, action queue and back.
// Uses svgt_pkg, svgt_if, svgt_front, svgt_queue and svgt_back.
module svg_path_command_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    svgt_char_if.sink    i_char,
    svgt_token_if.source o_token
);
    import svgt_pkg::*;

    logic    push;
    logic    pop;
    logic    q_full;
    logic    q_empty;
    t_action push_data;
    t_action head;

    // classification and parse state
    svgt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_char.valid),
        .i_char_code  (i_char.char_code),
        .o_ready      (i_char.ready),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_action     (push_data)
    );

    // decoupling queue
    svgt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // token expansion and output register
    svgt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_empty   (q_empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_token.valid),
        .i_ready        (o_token.ready),
        .o_token_kind   (o_token.token_kind),
        .o_move_type    (o_token.move_type),
        .o_digit_value  (o_token.digit_value),
        .o_number_start (o_token.number_start),
        .o_last         (o_token.last)
    );

endmodule
